// ----- rtl/hkc_pkg.sv -----
// shared types and constants of the hash keystream name cipher
package hkc_pkg;

   localparam int CsrIdxWidth = 3;
   localparam logic [CsrIdxWidth-1:0] CSR_KEY0 = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_KEY1 = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_KEY2 = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_KEY3 = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_NONCE_LO = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_NONCE_HI = 3'd5;

   localparam int PosWidth = 7;
   localparam int BlockBytes = 32;

   typedef struct packed {
      logic hash_start;
      logic [1:0] blk_sel;
   } hkc_cmd_type;

   typedef struct packed {
      logic hash_busy;
   } hkc_status_type;

   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] SHA_INIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   // four little-endian bytes of a 32-bit word into one big-endian message word
   function automatic logic [31:0] be_word(input logic [31:0] x);
      be_word = {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

endpackage

// ----- rtl/hkc_datapath.sv -----
// datapath: config registers, sha-256 round unit and keystream block
module hkc_datapath import hkc_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [63:0] csr_data,
   input  hkc_cmd_type cmd,
   output hkc_status_type status,
   input  logic [4:0] ks_index,
   output logic [7:0] ks_byte
);

   logic [63:0] key_ff [4];
   logic [63:0] nonce_lo_ff;
   logic [31:0] nonce_hi_ff;
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff;
   logic [5:0] round_ff;
   logic busy_ff;
   logic fin_ff;
   logic [255:0] ks_ff;

   logic [31:0] s0, s1, ch, mj, t1, t2, ws0, ws1, w_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         nonce_lo_ff <= '0;
         nonce_hi_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_KEY0: key_ff[0] <= csr_data;
            CSR_KEY1: key_ff[1] <= csr_data;
            CSR_KEY2: key_ff[2] <= csr_data;
            CSR_KEY3: key_ff[3] <= csr_data;
            CSR_NONCE_LO: nonce_lo_ff <= csr_data;
            CSR_NONCE_HI: nonce_hi_ff <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // message schedule as a 16-word sliding window
   always_comb begin
      ws0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      ws1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + ws0 + w_ff[9] + ws1;
      for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
      w_in[15] = w_new;
      s1 = rotr(e_ff, 6) ^ rotr(e_ff, 11) ^ rotr(e_ff, 25);
      ch = (e_ff & f_ff) ^ (~e_ff & g_ff);
      t1 = h_ff + s1 + ch + SHA_K[round_ff] + w_ff[0];
      s0 = rotr(a_ff, 2) ^ rotr(a_ff, 13) ^ rotr(a_ff, 22);
      mj = (a_ff & b_ff) ^ (a_ff & c_ff) ^ (b_ff & c_ff);
      t2 = s0 + mj;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff <= 1'b0;
         round_ff <= '0;
      end else if (cmd.hash_start) begin
         busy_ff <= 1'b1;
         fin_ff <= 1'b0;
         round_ff <= '0;
      end else if (fin_ff) begin
         fin_ff <= 1'b0;
         busy_ff <= 1'b0;
      end else if (busy_ff) begin
         round_ff <= round_ff + 6'd1;
         if (round_ff == 6'd63) fin_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hash_start) begin
         for (int i = 0; i < 4; i++) begin
            w_ff[2*i]   <= be_word(key_ff[i][31:0]);
            w_ff[2*i+1] <= be_word(key_ff[i][63:32]);
         end
         w_ff[8]  <= be_word(nonce_lo_ff[31:0]);
         w_ff[9]  <= be_word(nonce_lo_ff[63:32]);
         w_ff[10] <= be_word(nonce_hi_ff);
         w_ff[11] <= be_word({30'd0, cmd.blk_sel});
         w_ff[12] <= 32'h80000000;
         w_ff[13] <= 32'd0;
         w_ff[14] <= 32'd0;
         w_ff[15] <= 32'd384;
         a_ff <= SHA_INIT[0]; b_ff <= SHA_INIT[1];
         c_ff <= SHA_INIT[2]; d_ff <= SHA_INIT[3];
         e_ff <= SHA_INIT[4]; f_ff <= SHA_INIT[5];
         g_ff <= SHA_INIT[6]; h_ff <= SHA_INIT[7];
      end else if (busy_ff && !fin_ff) begin
         w_ff <= w_in;
         h_ff <= g_ff; g_ff <= f_ff; f_ff <= e_ff; e_ff <= d_ff + t1;
         d_ff <= c_ff; c_ff <= b_ff; b_ff <= a_ff; a_ff <= t1 + t2;
      end
   end

   // final add; digest byte i sits at ks_ff[8i+7:8i]
   always_ff @(posedge clock) begin
      if (fin_ff) begin
         ks_ff[31:0]    <= be_word(SHA_INIT[0] + a_ff);
         ks_ff[63:32]   <= be_word(SHA_INIT[1] + b_ff);
         ks_ff[95:64]   <= be_word(SHA_INIT[2] + c_ff);
         ks_ff[127:96]  <= be_word(SHA_INIT[3] + d_ff);
         ks_ff[159:128] <= be_word(SHA_INIT[4] + e_ff);
         ks_ff[191:160] <= be_word(SHA_INIT[5] + f_ff);
         ks_ff[223:192] <= be_word(SHA_INIT[6] + g_ff);
         ks_ff[255:224] <= be_word(SHA_INIT[7] + h_ff);
      end
   end

   assign ks_byte = ks_ff[{ks_index, 3'b000} +: 8];
   assign status.hash_busy = busy_ff;

endmodule

// ----- rtl/hkc_control.sv -----
// controller: name position, hash sequencing, counters and result register
module hkc_control import hkc_pkg::*; #(
   parameter int MaxNameBytes = 72
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_byte,
   input  logic req_first,
   input  logic req_last,
   input  logic req_dir,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [7:0] rsp_byte,
   output logic rsp_last,
   output logic [31:0] rsp_enc,
   output logic [31:0] rsp_dec,
   output hkc_cmd_type cmd,
   input  hkc_status_type status,
   output logic [4:0] ks_index,
   input  logic [7:0] ks_byte
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_HASH = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;
   localparam logic [PosWidth-1:0] MaxPos = PosWidth'(MaxNameBytes);

   logic [1:0] state_ff;
   logic [PosWidth-1:0] pos_ff, pos_ff_cur;
   logic [7:0] byte_ff;
   logic last_ff, dir_ff;
   logic [31:0] enc_ff, dec_ff;
   logic rsp_valid_ff;
   logic [7:0] rbyte_ff;
   logic rlast_ff;
   logic [31:0] renc_ff, rdec_ff;
   logic accept, end_name;
   logic [PosWidth-1:0] p_eff;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept = req_tvalid && req_tready;
   assign p_eff = req_first ? '0 : pos_ff;
   assign pos_ff_cur = pos_ff;
   assign end_name = last_ff || (pos_ff_cur + 7'd1 >= MaxPos);
   assign ks_index = pos_ff_cur[4:0];
   assign cmd.hash_start = accept && (p_eff < MaxPos) && (p_eff[4:0] == 5'd0);
   assign cmd.blk_sel = p_eff[6:5];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff <= '0;
         enc_ff <= '0;
         dec_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (accept && p_eff < MaxPos) begin
               pos_ff <= p_eff;
               byte_ff <= req_byte;
               last_ff <= req_last;
               dir_ff <= req_dir;
               state_ff <= cmd.hash_start ? ST_HASH : ST_EMIT;
            end else if (accept) begin
               pos_ff <= p_eff;
            end
            ST_HASH: if (!status.hash_busy) state_ff <= ST_EMIT;
            ST_EMIT: begin
               rsp_valid_ff <= 1'b1;
               rbyte_ff <= byte_ff ^ ks_byte;
               rlast_ff <= end_name;
               renc_ff <= (end_name && !dir_ff) ? enc_ff + 32'd1 : enc_ff;
               rdec_ff <= (end_name && dir_ff) ? dec_ff + 32'd1 : dec_ff;
               if (end_name && !dir_ff) enc_ff <= enc_ff + 32'd1;
               if (end_name && dir_ff) dec_ff <= dec_ff + 32'd1;
               pos_ff <= end_name ? MaxPos : pos_ff + 7'd1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_byte = rbyte_ff;
   assign rsp_last = rlast_ff;
   assign rsp_enc = renc_ff;
   assign rsp_dec = rdec_ff;

endmodule

// ----- rtl/hash_keystream_name_cipher_top.sv -----
// Name cipher with a SHA-256 counter-mode keystream. A byte at a 32-byte
// boundary of a name starts one SHA-256 compression (64 rounds, one per cycle)
// before its result is registered; every other byte uses the held keystream
// block. Each byte's result is registered before the next request is taken,
// so the round unit sets the pace of a name, and a result that waits holds off
// the next request. Configuration must be written only while no request is
// in flight; the block itself does not enforce this.
module hash_keystream_name_cipher_top import hkc_pkg::*; #(
   parameter int MaxNameBytes = 72
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,   // data_byte
   input  logic [1:0] req_tuser,   // first_of_name, direction
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [71:0] rsp_tdata,  // out_byte, names_encrypted_total, names_decrypted_total
   output logic rsp_tlast,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [63:0] csr_data
);

   hkc_cmd_type cmd;
   hkc_status_type status;
   logic [4:0] ks_index;
   logic [7:0] ks_byte;

   assign csr_ready = 1'b1;

   hkc_datapath u_dp (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .cmd(cmd), .status(status), .ks_index(ks_index), .ks_byte(ks_byte)
   );

   hkc_control #(.MaxNameBytes(MaxNameBytes)) u_ctl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_byte(req_tdata), .req_first(req_tuser[0]), .req_last(req_tlast),
      .req_dir(req_tuser[1]),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_byte(rsp_tdata[7:0]), .rsp_last(rsp_tlast),
      .rsp_enc(rsp_tdata[39:8]), .rsp_dec(rsp_tdata[71:40]),
      .cmd(cmd), .status(status), .ks_index(ks_index), .ks_byte(ks_byte)
   );

endmodule

// ----- tb/sv/tb.sv -----
// testbench of the hash keystream name cipher: directed and random names against a predictor
`timescale 1ns / 100ps

module tb import hkc_pkg::*;;

   localparam int NameCut = 72;
   localparam int StallLimit = 3000;

   typedef struct {
      logic [7:0] out_byte;
      logic out_last;
      logic [31:0] enc_total;
      logic [31:0] dec_total;
   } cipher_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   // predictor state
   logic [255:0] key_bits = '0;
   logic [95:0] nonce_bits = '0;
   logic [6:0] name_pos = '0;
   logic [255:0] stream_bytes = '0;
   logic [31:0] enc_names = '0;
   logic [31:0] dec_names = '0;
   cipher_rsp_type pending_rsp[$];

   int errors = 0;
   int idle_cycles = 0;
   int rsp_holdoff = 0;
   bit no_gaps = 0;

   hash_keystream_name_cipher_top dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // sha-256 of key, nonce and little-endian block number; hash byte i at bits 8i+7:8i
   function automatic logic [255:0] keystream_of(logic [255:0] k, logic [95:0] n,
                                                  logic [31:0] blk);
      logic [7:0] msg[64];
      logic [31:0] w[64];
      logic [31:0] h[8];
      logic [31:0] a, b, c, d, e, f, g, hh, t1, t2;
      logic [255:0] res;
      for (int i = 0; i < 64; i++) msg[i] = 8'h00;
      for (int i = 0; i < 32; i++) msg[i] = k[8*i +: 8];
      for (int i = 0; i < 12; i++) msg[32+i] = n[8*i +: 8];
      for (int i = 0; i < 4; i++) msg[44+i] = blk[8*i +: 8];
      msg[48] = 8'h80;
      msg[62] = 8'h01;
      msg[63] = 8'h80;
      for (int i = 0; i < 16; i++)
         w[i] = {msg[4*i], msg[4*i+1], msg[4*i+2], msg[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
              + w[i-7] + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
      for (int i = 0; i < 8; i++) h[i] = SHA_INIT[i];
      {a, b, c, d, e, f, g, hh} = {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
      for (int i = 0; i < 64; i++) begin
         t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
            + SHA_K[i] + w[i];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         hh = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      h[0] += a; h[1] += b; h[2] += c; h[3] += d;
      h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
      for (int i = 0; i < 32; i++) res[8*i +: 8] = 8'(h[i/4] >> (24 - 8 * (i % 4)));
      return res;
   endfunction

   // returns 1 when the byte gives a result
   function automatic bit cipher_byte(logic [7:0] data, logic first, logic last, logic dir);
      cipher_rsp_type r;
      logic [6:0] p;
      bit done;
      if (first) name_pos = '0;
      if (name_pos >= NameCut) return 0;
      p = name_pos;
      if (p[4:0] == 5'd0) stream_bytes = keystream_of(key_bits, nonce_bits, {30'd0, p[6:5]});
      done = last || (p + 1 >= NameCut);
      if (done) begin
         if (dir) dec_names++;
         else enc_names++;
         name_pos = 7'(NameCut);
      end else begin
         name_pos = p + 7'd1;
      end
      r.out_byte = data ^ stream_bytes[8*p[4:0] +: 8];
      r.out_last = done;
      r.enc_total = enc_names;
      r.dec_total = dec_names;
      pending_rsp.push_back(r);
      return 1;
   endfunction

   function automatic int draw_gap();
      return no_gaps ? 0 : $urandom_range(6);
   endfunction

   // one request; returns whether a result is due
   task automatic send_byte(logic [7:0] data, logic first, logic last, logic dir,
                            output bit gives_rsp);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = data;
      req_tuser = {dir, first};
      req_tlast = last;
      do @(posedge clock); while (!req_tready);
      gives_rsp = cipher_byte(data, first, last, dir);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic write_csr(logic [CsrIdxWidth-1:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_KEY0: key_bits[63:0] = value;
         CSR_KEY1: key_bits[127:64] = value;
         CSR_KEY2: key_bits[191:128] = value;
         CSR_KEY3: key_bits[255:192] = value;
         CSR_NONCE_LO: nonce_bits[63:0] = value;
         CSR_NONCE_HI: nonce_bits[95:64] = value[31:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // a byte past the cut may still be in flight: keep waiting after the queue empties
   task automatic drain();
      stop_sending();
      wait (pending_rsp.size() == 0);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_all_csrs(logic [63:0] k0, k1, k2, k3, nlo, logic [31:0] nhi);
      write_csr(CSR_KEY0, k0);
      write_csr(CSR_KEY1, k1);
      write_csr(CSR_KEY2, k2);
      write_csr(CSR_KEY3, k3);
      write_csr(CSR_NONCE_LO, nlo);
      write_csr(CSR_NONCE_HI, {32'd0, nhi});
   endtask

   task automatic send_name(int len, logic mark_last, logic dir);
      bit r;
      for (int i = 0; i < len; i++)
         send_byte(8'($urandom), i == 0, mark_last && i == len - 1, dir, r);
   endtask

   task automatic test_directed();
      bit r;
      // first byte after reset without a start flag, zero key
      send_byte(8'h00, 1'b0, 1'b0, 1'b0, r);
      send_byte(8'hff, 1'b0, 1'b1, 1'b1, r);
      send_byte(8'h5a, 1'b0, 1'b0, 1'b0, r);   // after the last mark: dropped
      send_byte(8'hff, 1'b1, 1'b1, 1'b0, r);   // one-byte name
      drain();
      write_all_csrs('1, '1, '1, '1, '1, '1);
      // full name with no last mark is cut at 72, then bytes past the cut
      send_name(NameCut + 3, 1'b0, 1'b1);
      // abandoned name, then mixed direction within a name
      send_name(5, 1'b0, 1'b0);
      send_byte(8'h01, 1'b1, 1'b0, 1'b1, r);
      send_byte(8'h80, 1'b0, 1'b1, 1'b0, r);
      drain();
      // key change between names: the next name's block uses the new key
      write_csr(CSR_KEY2, 64'h0123_4567_89ab_cdef);
      send_name(20, 1'b0, 1'b0);
      drain();
      write_csr(CSR_NONCE_HI, 64'h0000_0000_dead_beef);
      for (int i = 0; i < 20; i++) send_byte(8'($urandom), 1'b0, i == 19, 1'b1, r);
      drain();
   endtask

   task automatic test_backpressure();
      rsp_holdoff = 400;
      no_gaps = 1;
      send_name(40, 1'b1, 1'b0);
      no_gaps = 0;
      drain();
   endtask

   task automatic test_random(int target);
      int got;
      int len;
      bit r;
      got = 0;
      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 3) write_all_csrs('0, '0, '0, '0, '0, '0);
         else write_all_csrs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
         no_gaps = (phase == 1);
         while (got < target * (phase + 1) / 4) begin
            if ($urandom_range(9) == 0) begin
               send_byte(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), r);
               got += r;
            end else begin
               len = ($urandom_range(7) == 0) ? $urandom_range(NameCut + 4, 60)
                                              : $urandom_range(40, 1);
               for (int i = 0; i < len; i++) begin
                  send_byte(8'($urandom), i == 0, i == len - 1 && $urandom_range(5) != 0,
                            1'($urandom), r);
                  got += r;
               end
            end
         end
         drain();
      end
      no_gaps = 0;
   endtask

   // result side: random ready gaps plus one long hold-off
   initial begin
      int gap;
      forever begin
         @(negedge clock);
         gap = draw_gap() + rsp_holdoff;
         rsp_holdoff = 0;
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      cipher_rsp_type exp_rsp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result %h last %b", rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_tdata[7:0] !== exp_rsp.out_byte) begin
               $error("out_byte expected %h got %h", exp_rsp.out_byte, rsp_tdata[7:0]);
               errors++;
            end
            if (rsp_tlast !== exp_rsp.out_last) begin
               $error("out_last expected %b got %b", exp_rsp.out_last, rsp_tlast);
               errors++;
            end
            if (rsp_tdata[39:8] !== exp_rsp.enc_total) begin
               $error("names_encrypted_total expected %0d got %0d",
                      exp_rsp.enc_total, rsp_tdata[39:8]);
               errors++;
            end
            if (rsp_tdata[71:40] !== exp_rsp.dec_total) begin
               $error("names_decrypted_total expected %0d got %0d",
                      exp_rsp.dec_total, rsp_tdata[71:40]);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_backpressure();
      test_random(330);
      drain();
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
